// ===== hdl/tsme_pkg.sv =====
// Package for the two-set membership engine: command codes, status codes,
// sequencer states and default sizes. No dependencies.
`timescale 1ns / 1ps
package tsme_pkg;

  localparam int DefCapacity   = 32;
  localparam int DefValueWidth = 32;
  localparam int CountWidth    = 6;

  typedef enum logic [3:0] {
    CMD_INSERT    = 4'd0,
    CMD_MEMBER    = 4'd1,
    CMD_COUNT     = 4'd2,
    CMD_SUBSET    = 4'd3,
    CMD_EQUAL     = 4'd4,
    CMD_UNION     = 4'd5,
    CMD_INTERSECT = 4'd6,
    CMD_DIFF      = 4'd7,
    CMD_SYMDIFF   = 4'd8,
    CMD_CLEAR     = 4'd9
  } cmd_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Sequencer states. Each pass walks one "outer" set (source) and for each
  // of its entries walks the "inner" (check) set.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OREAD,   // read outer entry
    ST_OWAIT,   // outer data arrives
    ST_IREAD,   // inner scan, one entry per cycle
    ST_IDONE,   // last inner compare done
    ST_FINISH
  } state_t;

  // Memory access request from the sequencer to the store.
  typedef struct packed {
    logic       rd_en;
    logic       rd_set;   // 0 A, 1 B
    logic [4:0] rd_addr;
    logic       wr_en;
    logic       wr_set;
    logic [4:0] wr_addr;
  } mem_req_t;

endpackage

// ===== hdl/tsme_store.sv =====
// Element storage for sets A and B: one synchronous RAM with a
// registered read port. Depends on tsme_pkg.
`timescale 1ns / 1ps
module tsme_store
  import tsme_pkg::*;
#(
  parameter int SET_CAPACITY = DefCapacity,
  parameter int VALUE_WIDTH  = DefValueWidth
) (
  input  logic                   clk,
  input  mem_req_t               req,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  output logic [VALUE_WIDTH-1:0] rd_data
);
  localparam int AW = $clog2(SET_CAPACITY);
  localparam int DEPTH = 2 * (1 << AW);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[{req.wr_set, req.wr_addr[AW-1:0]}] <= wr_data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[{req.rd_set, req.rd_addr[AW-1:0]}];
  end
endmodule

// ===== hdl/two_set_membership_engine.sv =====
// Two-set membership engine top level: command sequencer around the set
// store. Depends on tsme_pkg and tsme_store.
//
// Usage: drive cmd, set_sel and value with start high while busy is low; that
// beat is accepted. Each command yields one or more result beats, each shown
// for exactly one cycle with strobe high; last marks the final beat. The
// receiver cannot stall, so results are dropped onto the ports in order.
// Count, clear and unused codes go from the read state straight to the
// finish state, which sends their single beat. Insert and member scan the
// selected set once, ending early on a hit. Subset, equal and the streaming
// operations run an outer scan over one set with an inner scan over the
// other through the single memory read port, in up to two passes; the read
// port is what bounds their running time. A streamed element is held until
// the next one is found, so last can ride on the final element beat. A new
// command is accepted from the cycle in which the final beat is shown. Reset
// empties both sets (sizes to zero) at once; no clearing pass is needed since
// only entries below the size are read. An empty stream gives one beat with
// element_valid low.
`timescale 1ns / 1ps
module two_set_membership_engine
  import tsme_pkg::*;
#(
  parameter int SET_CAPACITY = DefCapacity,
  parameter int VALUE_WIDTH  = DefValueWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         cmd,
  input  logic               set_sel,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic signed [31:0] element,
  output logic               element_valid,
  output logic               answer,
  output logic [5:0]         count,
  output logic [1:0]         status,
  output logic               last
);
  localparam logic [5:0] CAP = 6'(SET_CAPACITY);

  state_t state, state_next;
  mem_req_t req;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic [5:0] size_a, size_b;
  logic [3:0] op;
  logic       sel;
  logic [VALUE_WIDTH-1:0] val;
  logic       pass;      // 0 first pass, 1 second pass
  logic [5:0] oidx, iidx;
  logic [VALUE_WIDTH-1:0] oval;
  logic       hit;       // inner scan found outer value
  logic       ok;        // subset/equal accumulator
  logic       emitted;   // an element is held in hold_val
  logic [VALUE_WIDTH-1:0] hold_val;  // newest element, sent once the next is known or at finish
  logic       rd_pend;   // inner read issued last cycle
  logic       strobe_next;

  tsme_store #(.SET_CAPACITY(SET_CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
    .clk(clk), .req(req), .wr_data(val), .rd_data(rd_data)
  );

  // which set the passes walk
  logic       outer_set, inner_set;
  logic [5:0] outer_size, inner_size;
  logic       want;      // emit when hit==want
  logic       is_stream, single_pass, scan_self;
  logic [5:0] sel_size;

  always_comb begin
    sel_size  = sel ? size_b : size_a;
    is_stream = (op == CMD_UNION) || (op == CMD_INTERSECT) ||
                (op == CMD_DIFF) || (op == CMD_SYMDIFF);
    scan_self = (op == CMD_INSERT) || (op == CMD_MEMBER);
    single_pass = (op == CMD_SUBSET) || (op == CMD_INTERSECT) || (op == CMD_DIFF);
    // insert/member scan the selected set itself
    // pass 0: outer=selected except subset/intersect (outer=other)
    if (scan_self) begin
      outer_set = sel;
      inner_set = sel;
    end else if ((op == CMD_SUBSET) || (op == CMD_INTERSECT) || pass) begin
      outer_set = ~sel;
      inner_set = sel;
    end else begin
      outer_set = sel;
      inner_set = ~sel;
    end
    outer_size = outer_set ? size_b : size_a;
    inner_size = inner_set ? size_b : size_a;
    // union first pass emits selected set unfiltered
    if (op == CMD_UNION && !pass) inner_size = 6'd0;
    want = (op == CMD_INTERSECT) || (op == CMD_SUBSET) || (op == CMD_EQUAL);
  end

  logic match;
  assign match = rd_pend && (rd_data == oval);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequencer next state, memory requests, result beat
  logic       out_stb, out_ans, start_ok;
  logic [1:0] out_st;
  logic       inner_done;
  always_comb begin
    state_next = state;
    req = '0;
    out_stb = 1'b0; out_ans = 1'b0;
    out_st = STAT_OK;
    start_ok = start && (state == ST_IDLE);
    inner_done = (iidx >= inner_size);
    case (state)
      ST_IDLE: if (start_ok) state_next = ST_OREAD;
      ST_OREAD: begin
        if (scan_self) begin
          state_next = ST_IREAD;
        end else if (op == CMD_COUNT || op == CMD_CLEAR || op > CMD_CLEAR) begin
          state_next = ST_FINISH;
        end else if (oidx >= outer_size) begin
          if (!pass && !single_pass) state_next = ST_OREAD;
          else state_next = ST_FINISH;
        end else begin
          req.rd_en = 1'b1; req.rd_set = outer_set; req.rd_addr = 5'(oidx);
          state_next = ST_OWAIT;
        end
      end
      ST_OWAIT: state_next = ST_IREAD;
      ST_IREAD: begin
        if (match || hit || inner_done) begin
          state_next = ST_IDONE;
        end else begin
          req.rd_en = 1'b1; req.rd_set = inner_set; req.rd_addr = 5'(iidx);
        end
      end
      ST_IDONE: begin
        if (scan_self) begin
          state_next = ST_FINISH;
        end else begin
          if (is_stream && (hit == want)) out_stb = 1'b1;
          state_next = ST_OREAD;
        end
      end
      ST_FINISH: begin
        if (op == CMD_MEMBER) out_ans = hit;
        if (op == CMD_SUBSET || op == CMD_EQUAL) out_ans = ok;
        if (op == CMD_INSERT) begin
          if (hit) out_st = STAT_DUP;
          else if (sel_size >= CAP) out_st = STAT_FULL;
          else begin
            req.wr_en = 1'b1; req.wr_set = sel; req.wr_addr = 5'(sel_size);
          end
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a beat goes out when a new element releases the held one, and at finish
  assign strobe_next = (state == ST_FINISH) || ((state == ST_IDONE) && out_stb && emitted);

  // datapath registers
  logic [5:0] sel_size_after;
  always_comb begin
    sel_size_after = sel_size;
    if (op == CMD_CLEAR) sel_size_after = '0;
    else if (op == CMD_INSERT && !hit && sel_size < CAP) sel_size_after = sel_size + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_a <= '0; size_b <= '0;
      emitted <= 1'b0; rd_pend <= 1'b0;
      strobe <= 1'b0;
    end else begin
      rd_pend <= req.rd_en && (state == ST_IREAD);
      strobe <= strobe_next;
      case (state)
        ST_IDLE: if (start_ok) begin
          op <= cmd; sel <= set_sel;
          val <= value[VALUE_WIDTH-1:0];
          pass <= 1'b0; oidx <= '0; iidx <= '0; hit <= 1'b0; ok <= 1'b1;
          emitted <= 1'b0;
        end
        ST_OREAD: if (!scan_self && oidx >= outer_size && !pass && !single_pass) begin
          pass <= 1'b1; oidx <= '0;
        end else if (scan_self) begin
          oval <= val; iidx <= '0; hit <= 1'b0;
        end
        ST_OWAIT: begin
          oval <= rd_data; iidx <= '0; hit <= 1'b0;
        end
        ST_IREAD: begin
          if (match) hit <= 1'b1;
          if (req.rd_en) iidx <= iidx + 6'd1;
        end
        ST_IDONE: begin
          oidx <= oidx + 6'd1;
          if (!hit && (op == CMD_SUBSET || op == CMD_EQUAL)) ok <= 1'b0;
          // new element: send the held one, hold the new one
          if (out_stb) begin
            hold_val <= oval;
            emitted <= 1'b1;
            if (emitted) begin
              element <= 32'(signed'(hold_val));
              element_valid <= 1'b1; answer <= 1'b0; status <= STAT_OK;
              count <= sel_size; last <= 1'b0;
            end
          end
        end
        ST_FINISH: begin
          if (sel) size_b <= sel_size_after; else size_a <= sel_size_after;
          if (is_stream && emitted) begin
            element <= 32'(signed'(hold_val)); element_valid <= 1'b1;
            answer <= 1'b0; status <= STAT_OK;
            count <= sel_size_after; last <= 1'b1;
          end else begin
            element <= '0; element_valid <= 1'b0;
            answer <= out_ans; status <= out_st;
            count <= sel_size_after; last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  // accepted command makes the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy);
  // a beat without an element closes the command
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !element_valid) |-> last);
  // the closing beat comes with the engine idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy);
  // set sizes stay within capacity
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    (size_a <= CAP) && (size_b <= CAP));
  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (status <= STAT_FULL));
endmodule

// ===== bench/tb_two_set_membership_engine.sv =====
// Testbench for two_set_membership_engine: directed table then random commands,
// each result beat checked against a behavioral set model. Depends on tsme_pkg and two_set_membership_engine.
`timescale 1ns / 1ps
module tb_two_set_membership_engine
  import tsme_pkg::*;
;

  localparam int Cap = DefCapacity;

  typedef struct packed {
    logic signed [31:0] element;
    logic               element_valid;
    logic               answer;
    logic [5:0]         count;
    logic [1:0]         status;
    logic               last;
  } beat_t;

  typedef struct {
    logic [3:0]  cmd;
    logic        sel;
    logic [31:0] val;
    logic        typed;   // expected beat given in the row
    beat_t       exp_beat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] cmd = '0;
  logic set_sel = 1'b0;
  logic signed [31:0] value = '0;
  logic busy, strobe, element_valid, answer, last;
  logic signed [31:0] element;
  logic [5:0] count;
  logic [1:0] status;

  // model state
  logic [31:0] set_vals [2][Cap];
  int          set_len [2];
  beat_t       pending_beats[$];

  int errors = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  two_set_membership_engine i_dut (
    .clk, .rst, .start, .busy, .cmd, .set_sel, .value, .strobe,
    .element, .element_valid, .answer, .count, .status, .last
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit holds(int s, logic [31:0] v);
    for (int i = 0; i < set_len[s]; i++)
      if (set_vals[s][i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic beat_t mk_beat(logic [31:0] e, logic ev, logic a, int c,
                                    logic [1:0] st);
    beat_t b;
    b.element = e;
    b.element_valid = ev;
    b.answer = a;
    b.count = c[5:0];
    b.status = st;
    b.last = 1'b0;
    return b;
  endfunction

  // Push elements of src that are (want=1) or are not in chk; chk < 0 means none.
  task automatic stream_filtered(int src, int chk, bit want, int cnt, ref int n);
    for (int i = 0; i < set_len[src]; i++)
      if (((chk >= 0) && holds(chk, set_vals[src][i])) == want) begin
        pending_beats.push_back(mk_beat(set_vals[src][i], 1'b1, 1'b0, cnt, STAT_OK));
        n++;
      end
  endtask

  // Apply one command to the set model and queue its result beats.
  task automatic predict_sets(logic [3:0] c, logic sel, logic [31:0] v);
    int s, o, n;
    logic [1:0] st;
    logic ans;
    beat_t b;
    s = sel;
    o = 1 - s;
    n = 0;
    st = STAT_OK;
    ans = 1'b0;
    case (c)
      CMD_INSERT: begin
        if (holds(s, v)) st = STAT_DUP;
        else if (set_len[s] >= Cap) st = STAT_FULL;
        else begin
          set_vals[s][set_len[s]] = v;
          set_len[s]++;
        end
      end
      CMD_MEMBER: ans = holds(s, v);
      CMD_SUBSET, CMD_EQUAL: begin
        ans = 1'b1;
        for (int i = 0; i < set_len[o]; i++)
          if (!holds(s, set_vals[o][i])) ans = 1'b0;
        if (c == CMD_EQUAL)
          for (int i = 0; i < set_len[s]; i++)
            if (!holds(o, set_vals[s][i])) ans = 1'b0;
      end
      CMD_UNION: begin
        stream_filtered(s, -1, 1'b0, set_len[s], n);
        stream_filtered(o, s, 1'b0, set_len[s], n);
      end
      CMD_INTERSECT: stream_filtered(o, s, 1'b1, set_len[s], n);
      CMD_DIFF: stream_filtered(s, o, 1'b0, set_len[s], n);
      CMD_SYMDIFF: begin
        stream_filtered(s, o, 1'b0, set_len[s], n);
        stream_filtered(o, s, 1'b0, set_len[s], n);
      end
      CMD_CLEAR: set_len[s] = 0;
      default: ;
    endcase
    if (n == 0) pending_beats.push_back(mk_beat('0, 1'b0, ans, set_len[s], st));
    b = pending_beats[$];
    b.last = 1'b1;
    pending_beats[$] = b;
  endtask

  // Result checker: every strobe beat against the oldest expectation.
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && strobe) begin
      got = {element, element_valid, answer, count, status, last};
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: cycles with nothing accepted and no result beat.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** two_set_membership_engine: FAILED **");
      $finish;
    end
  end

  // Drive one command and wait for acceptance, then drop start.
  task automatic issue_cmd(logic [3:0] c, logic sel, logic [31:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    set_sel <= sel;
    value <= v;
    do @(posedge clk); while (busy);
    predict_sets(c, sel, v);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t row(logic [3:0] c, logic sel, logic [31:0] v, int t,
                               int a, int n, logic [1:0] st);
    row_t r;
    r.cmd = c;
    r.sel = sel;
    r.val = v;
    r.typed = (t != 0);
    r.exp_beat = mk_beat('0, 1'b0, (a != 0), n, st);
    r.exp_beat.last = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] rand_val(int s);
    int pick;
    pick = $urandom_range(9);
    if (pick < 4 && set_len[s] > 0) return set_vals[s][$urandom_range(set_len[s] - 1)];
    if (pick < 7) return 32'($urandom_range(15)) - 32'd8;
    return $urandom;
  endfunction

  initial begin
    row_t dir[$];
    int phase;
    logic [3:0] c;
    logic sel;
    for (int s = 0; s < 2; s++) set_len[s] = 0;
    // directed table; typed rows carry their expected beat
    dir.push_back(row(CMD_COUNT, 1'b0, 0, 1, 0, 0, STAT_OK));
    dir.push_back(row(CMD_UNION, 1'b0, 0, 0, 0, 0, STAT_OK));       // empty stream
    dir.push_back(row(CMD_SUBSET, 1'b0, 0, 1, 1, 0, STAT_OK));      // empty subset
    dir.push_back(row(CMD_INSERT, 1'b0, 32'h8000_0000, 1, 0, 1, STAT_OK));
    dir.push_back(row(CMD_INSERT, 1'b0, 32'h7FFF_FFFF, 1, 0, 2, STAT_OK));
    dir.push_back(row(CMD_INSERT, 1'b0, 32'h8000_0000, 1, 0, 2, STAT_DUP));
    dir.push_back(row(CMD_INSERT, 1'b0, 32'hFFFF_FFFF, 1, 0, 3, STAT_OK));
    dir.push_back(row(CMD_INSERT, 1'b1, 32'h0, 1, 0, 1, STAT_OK));
    dir.push_back(row(CMD_INSERT, 1'b1, 32'h7FFF_FFFF, 1, 0, 2, STAT_OK));
    dir.push_back(row(CMD_MEMBER, 1'b0, 32'h7FFF_FFFF, 1, 1, 3, STAT_OK));
    dir.push_back(row(CMD_MEMBER, 1'b1, 32'h8000_0000, 1, 0, 2, STAT_OK));
    dir.push_back(row(CMD_SUBSET, 1'b1, 0, 0, 0, 0, STAT_OK));
    dir.push_back(row(CMD_EQUAL, 1'b0, 0, 1, 0, 3, STAT_OK));
    dir.push_back(row(CMD_UNION, 1'b0, 0, 0, 0, 0, STAT_OK));
    dir.push_back(row(CMD_INTERSECT, 1'b1, 0, 0, 0, 0, STAT_OK));
    dir.push_back(row(CMD_DIFF, 1'b0, 0, 0, 0, 0, STAT_OK));
    dir.push_back(row(CMD_SYMDIFF, 1'b1, 0, 0, 0, 0, STAT_OK));
    dir.push_back(row(4'd10, 1'b0, 0, 1, 0, 3, STAT_OK));
    dir.push_back(row(4'd15, 1'b1, 32'hFFFF_FFFF, 1, 0, 2, STAT_OK));
    dir.push_back(row(CMD_CLEAR, 1'b1, 0, 1, 0, 0, STAT_OK));
    dir.push_back(row(CMD_EQUAL, 1'b1, 0, 1, 0, 0, STAT_OK));
    dir.push_back(row(CMD_CLEAR, 1'b0, 0, 1, 0, 0, STAT_OK));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (dir[i]) begin
      issue_cmd(dir[i].cmd, dir[i].sel, dir[i].val);
      if (dir[i].typed && pending_beats[$] !== dir[i].exp_beat) begin
        errors++;
        if (errors <= 10)
          $display("row %0d: table %p, model %p", i, dir[i].exp_beat, pending_beats[$]);
      end
    end

    // fill A to capacity and overflow it
    for (int i = 0; i < Cap + 2; i++) issue_cmd(CMD_INSERT, 1'b0, 32'(i * 3 - 40));
    issue_cmd(CMD_INSERT, 1'b0, 32'h7FFF_FFFF);
    issue_cmd(CMD_SYMDIFF, 1'b0, 0);
    issue_cmd(CMD_UNION, 1'b1, 0);

    // pause until every expected beat is out
    while (pending_beats.size() != 0) @(posedge clk);

    // random part in idling phases
    for (int n = 0; n < 240; n++) begin
      phase = n / 60;
      sender_idle_pct = (phase == 1) ? 69 : (phase == 3) ? 20 : 0;
      sel = 1'($urandom_range(1));
      if ($urandom_range(99) < 45) c = CMD_INSERT;
      else if ($urandom_range(99) < 3) c = CMD_CLEAR;
      else if ($urandom_range(99) < 4) c = 4'($urandom_range(15, 10));
      else c = 4'($urandom_range(8, 1));
      issue_cmd(c, sel, rand_val(c == CMD_MEMBER || c == CMD_INSERT ? sel : 1 - sel));
    end

    // drain, then tail
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (2300) @(posedge clk);
    if (errors == 0 && pending_beats.size() == 0)
      $display("** two_set_membership_engine: PASSED **");
    else
      $display("** two_set_membership_engine: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tsme_pkg.sv
hdl/tsme_store.sv
hdl/two_set_membership_engine.sv
bench/tb_two_set_membership_engine.sv
